[sv/xtea_block_cipher_unit_defines.svh]
// Assertion macros shared by the XTEA cipher unit.
`ifndef XTEA_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define XTEA_BLOCK_CIPHER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define XTEA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("xtea same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define XTEA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("xtea next-cycle check failed");

`else

`define XTEA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define XTEA_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[sv/xtea_pkg.sv]
// Types, constants and the round mixing function of the XTEA cipher unit.
`default_nettype none

package xtea_pkg;

    // Round constant of the key schedule.
    localparam logic [31:0] DELTA = 32'h9E37_79B9;

    // Number of key words and the width of the register address.
    localparam int KEY_WORDS = 4;
    localparam int ADDR_W    = 4;

    // Encrypt and decrypt codes of the function bit.
    localparam logic FUNC_ENC = 1'b0;
    localparam logic FUNC_DEC = 1'b1;

    // Full 128-bit key as four words.
    typedef logic [KEY_WORDS-1:0][31:0] t_key_set;

    // One pipeline word: valid bit, function bit and both block halves.
    typedef struct packed {
        logic        valid;
        logic        func;
        logic [31:0] v0;
        logic [31:0] v1;
    } t_stage;

    // Feistel mixing term of one half-round.
    function automatic logic [31:0] mix_word(input logic [31:0] v,
                                             input logic [31:0] s,
                                             input logic [31:0] k);
        return (((v << 4) ^ (v >> 5)) + v) ^ (s + k);
    endfunction

endpackage

`default_nettype wire

[sv/xtea_block_cipher_unit.sv]
// Top level of the pipelined XTEA cipher unit.
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_stall   i_func, i_first_word, i_second_word
//   output    out        o_valid / i_stall   o_first_result, o_second_result
//   config    in         psel/penable/pready paddr, pwdata, prdata (key words)
//
// Each round has its own register stage, so an accepted word passes through every
// round register to the output register; one word can enter every cycle while o_stall is low.
// The last round register is the output register.
// Reset clears the key words and every stage valid bit.
// A stage loads whenever it holds a bubble or the stage after it moves, so
// bubbles fill up behind a stalled output; o_stall rises only when all
// stages hold words and the output is stalled.
`default_nettype none
`include "xtea_block_cipher_unit_defines.svh"

module xtea_block_cipher_unit #(
    parameter int CYCLES = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_func,
    input  wire logic [31:0]                 i_first_word,
    input  wire logic [31:0]                 i_second_word,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic      [31:0]                 o_first_result,
    output logic      [31:0]                 o_second_result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [xtea_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);

    xtea_pkg::t_key_set w_key;
    xtea_pkg::t_stage   w_stage [CYCLES+1];
    logic [CYCLES:0]    w_en;
    logic [CYCLES-1:0]  w_valid;

    // Key registers.
    xtea_keys u_keys (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_key   (w_key)
    );

    // Incoming word feeds the first round.
    assign w_stage[0] = '{valid: i_valid, func: i_func,
                          v0: i_first_word, v1: i_second_word};

    // The output register moves when empty or when the sink takes it.
    assign w_en[CYCLES] = !w_stage[CYCLES].valid || !i_stall;

    // Round pipeline with bubble-filling load enables.
    for (genvar g = 0; g < CYCLES; g++) begin : g_round
        assign w_en[g]    = !w_stage[g+1].valid || w_en[g+1];
        assign w_valid[g] = w_stage[g+1].valid;

        xtea_round #(
            .ROUND  (g),
            .CYCLES (CYCLES)
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en[g]),
            .i_stage (w_stage[g]),
            .i_key   (w_key),
            .o_stage (w_stage[g+1])
        );
    end

    assign o_stall         = !w_en[0];
    assign o_valid         = w_stage[CYCLES].valid;
    assign o_first_result  = w_stage[CYCLES].v0;
    assign o_second_result = w_stage[CYCLES].v1;

    // The input is held off only when the pipeline is full.
    `XTEA_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, o_stall, (&w_valid))

    // The input is held off only behind a stalled result word.
    `XTEA_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_stall, (o_valid && i_stall))

    // An accepted word occupies the first stage on the next cycle.
    `XTEA_ASSERT_NXT(a_enter, i_clk, i_rst_n, (i_valid && !o_stall), w_valid[0])

endmodule

`default_nettype wire

[sv/xtea_keys.sv]
// Key register file behind the APB-style configuration port.
`default_nettype none

module xtea_keys (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [xtea_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output xtea_pkg::t_key_set              o_key
);

    xtea_pkg::t_key_set r_key;
    xtea_pkg::t_key_set n_key;
    logic [1:0]         w_index;

    // Registers sit at byte addresses 0, 4, 8 and 12.
    assign w_index = paddr[3:2];

    // A write lands in the access phase.
    always_comb begin
        n_key = r_key;
        if (psel && penable && pwrite) begin
            n_key[w_index] = pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else begin
            r_key <= n_key;
        end
    end

    // Reads return the addressed key word, with no wait states.
    assign prdata = r_key[w_index];
    assign pready = 1'b1;
    assign o_key  = r_key;

endmodule

`default_nettype wire

[sv/xtea_round.sv]
// One XTEA round (two half-rounds) with its pipeline register.
`default_nettype none

module xtea_round #(
    parameter int ROUND  = 0,
    parameter int CYCLES = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire xtea_pkg::t_stage  i_stage,
    input  wire xtea_pkg::t_key_set i_key,
    output xtea_pkg::t_stage       o_stage
);

    // Sums before and after this round, fixed at elaboration.
    localparam logic [31:0] ENC_SUM_A = 32'(ROUND) * xtea_pkg::DELTA;
    localparam logic [31:0] ENC_SUM_B = 32'(ROUND + 1) * xtea_pkg::DELTA;
    localparam logic [31:0] DEC_SUM_A = 32'(CYCLES - ROUND) * xtea_pkg::DELTA;
    localparam logic [31:0] DEC_SUM_B = 32'(CYCLES - ROUND - 1) * xtea_pkg::DELTA;

    // Key word indexes follow from those sums.
    localparam logic [1:0] ENC_KA = ENC_SUM_A[1:0];
    localparam logic [1:0] ENC_KB = ENC_SUM_B[12:11];
    localparam logic [1:0] DEC_KA = DEC_SUM_A[12:11];
    localparam logic [1:0] DEC_KB = DEC_SUM_B[1:0];

    xtea_pkg::t_stage r_stage;
    xtea_pkg::t_stage n_stage;
    logic [31:0]      w_enc0;
    logic [31:0]      w_enc1;
    logic [31:0]      w_dec0;
    logic [31:0]      w_dec1;

    // Encryption updates v0 then v1; decryption undoes v1 then v0.
    always_comb begin
        w_enc0 = i_stage.v0
               + xtea_pkg::mix_word(i_stage.v1, ENC_SUM_A, i_key[ENC_KA]);
        w_enc1 = i_stage.v1
               + xtea_pkg::mix_word(w_enc0, ENC_SUM_B, i_key[ENC_KB]);
        w_dec1 = i_stage.v1
               - xtea_pkg::mix_word(i_stage.v0, DEC_SUM_A, i_key[DEC_KA]);
        w_dec0 = i_stage.v0
               - xtea_pkg::mix_word(w_dec1, DEC_SUM_B, i_key[DEC_KB]);

        n_stage       = i_stage;
        if (i_stage.func == xtea_pkg::FUNC_DEC) begin
            n_stage.v0 = w_dec0;
            n_stage.v1 = w_dec1;
        end else begin
            n_stage.v0 = w_enc0;
            n_stage.v1 = w_enc1;
        end
    end

    // Only the valid bit is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

`default_nettype wire
